// ===== hdl/mma_pkg.sv =====
// Shared types and constants for the modular multiply-accumulate block.
package mma_pkg;
    localparam int MOD_W = 31;
    typedef logic [MOD_W-1:0] mod_t;
endpackage

// ===== hdl/modular_multiply_accumulate.sv =====
// Top level of the modular multiply-accumulate block.
//  channel | dir | payload
//  s_axis  | in  | a_value, b_value, modulus, last
//  m_axis  | out | residue_sum
// Each word passes through the shared one-bit-per-cycle remainder unit, used for four
// reductions, before the back end takes the next word; a word with a zero modulus
// skips the remainder unit.
// The front FIFO holds two words so input is taken while the back end works;
// the back end waits while a result word is held by the receiver.
// aresetn is synchronous, active low, and clears the total to zero.
module modular_multiply_accumulate import mma_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // a_value, b_value, modulus, padding
    input  logic [((2*DATA_WIDTH+31+7)/8)*8-1:0] s_axis_tdata,
    input  logic                    s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // residue_sum, padding
    output logic [31:0]             m_axis_tdata
);
    logic q_valid, q_ready, q_last;
    logic [DATA_WIDTH-1:0] q_a, q_b;
    mod_t q_m, sum;

    mma_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_a(s_axis_tdata[DATA_WIDTH-1:0]),
        .in_b(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .in_m(s_axis_tdata[2*DATA_WIDTH+MOD_W-1:2*DATA_WIDTH]), .in_last(s_axis_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_a(q_a), .q_b(q_b), .q_m(q_m),
        .q_last(q_last)
    );

    mma_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_a(q_a), .q_b(q_b), .q_m(q_m), .q_last(q_last),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_sum(sum)
    );

    assign m_axis_tdata = {1'b0, sum};

`ifndef SYNTH
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result word after reset");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
`endif
endmodule

// ===== hdl/mma_front.sv =====
// Front end: accepts words and queues them in a short FIFO for the back end.
module mma_front import mma_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_a,
    input  logic [DATA_WIDTH-1:0] in_b,
    input  mod_t                  in_m,
    input  logic                  in_last,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [DATA_WIDTH-1:0] q_a,
    output logic [DATA_WIDTH-1:0] q_b,
    output mod_t                  q_m,
    output logic                  q_last
);
    localparam int W = 2*DATA_WIDTH + MOD_W + 1;
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;
    assign {q_a, q_b, q_m, q_last} = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) mem_reg[wp_reg] <= {in_a, in_b, in_m, in_last};
    end
endmodule

// ===== hdl/mma_divmod.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
module mma_divmod import mma_pkg::*; #(
    parameter int NW = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  mod_t          den,
    output logic          busy,
    output logic          done,
    output mod_t          rem
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] n_reg;
    logic [MOD_W:0] r_reg, trial;
    mod_t          d_reg;
    logic [CW-1:0] c_reg;
    logic          busy_reg, done_reg;

    assign trial = {r_reg[MOD_W-1:0], n_reg[NW-1]};
    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = r_reg[MOD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                c_reg    <= CW'(NW);
                n_reg    <= num;
                d_reg    <= den;
                r_reg    <= '0;
            end else if (busy_reg) begin
                n_reg <= n_reg << 1;
                r_reg <= (trial >= {1'b0, d_reg}) ? trial - {1'b0, d_reg} : trial;
                c_reg <= c_reg - 1'b1;
                if (c_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/mma_back.sv =====
// Back end: reduces operands and product, accumulates and emits totals.
module mma_back import mma_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [DATA_WIDTH-1:0] q_a,
    input  logic [DATA_WIDTH-1:0] q_b,
    input  mod_t                  q_m,
    input  logic                  q_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mod_t                  out_sum
);
    localparam int NW = (DATA_WIDTH > 2*MOD_W) ? DATA_WIDTH : 2*MOD_W;
    typedef enum logic [2:0] {IDLE, RED_A, RED_B, MUL, RED_P, ACC, EMIT} state_t;
    state_t state_reg;
    logic [DATA_WIDTH-1:0] a_reg, b_reg;
    mod_t m_reg, ra_reg, rb_reg, tot_reg, sum_reg;
    logic last_reg, out_valid_reg, go_reg, neg_reg;
    logic [2*MOD_W-1:0] prod_reg;
    logic [NW-1:0] num;
    logic [DATA_WIDTH-1:0] mag_a, mag_b;
    logic dv_busy, dv_done;
    mod_t dv_rem, fixed;
    logic [MOD_W:0] acc;

    mma_divmod #(.NW(NW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(go_reg), .num(num), .den(m_reg),
        .busy(dv_busy), .done(dv_done), .rem(dv_rem)
    );

    // Negative operands are reduced by magnitude, then folded to the floor residue.
    always_comb begin
        mag_a = a_reg[DATA_WIDTH-1] ? (~a_reg + 1'b1) : a_reg;
        mag_b = b_reg[DATA_WIDTH-1] ? (~b_reg + 1'b1) : b_reg;
        num = '0;
        unique case (state_reg)
            RED_A:       num = NW'(mag_a);
            RED_B:       num = NW'(mag_b);
            RED_P, EMIT: num = NW'(prod_reg);
            default:     num = '0;
        endcase
        fixed = (neg_reg && dv_rem != '0) ? m_reg - dv_rem : dv_rem;
        acc = {1'b0, tot_reg} + {1'b0, ra_reg};
    end

    assign q_ready   = (state_reg == IDLE) && !out_valid_reg && !dv_busy;
    assign out_valid = out_valid_reg;
    assign out_sum   = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            go_reg        <= 1'b0;
            tot_reg       <= '0;
        end else begin
            go_reg <= 1'b0;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE: if (q_valid && q_ready) begin
                    a_reg <= q_a; b_reg <= q_b; m_reg <= q_m; last_reg <= q_last;
                    if (q_m == '0) begin
                        ra_reg <= '0; tot_reg <= '0; state_reg <= ACC;
                    end else begin
                        neg_reg <= q_a[DATA_WIDTH-1]; go_reg <= 1'b1; state_reg <= RED_A;
                    end
                end
                RED_A: if (dv_done) begin
                    ra_reg <= fixed; neg_reg <= b_reg[DATA_WIDTH-1];
                    go_reg <= 1'b1; state_reg <= RED_B;
                end
                RED_B: if (dv_done) begin
                    rb_reg <= fixed; state_reg <= MUL;
                end
                MUL: begin
                    prod_reg <= ra_reg * rb_reg; neg_reg <= 1'b0;
                    go_reg <= 1'b1; state_reg <= RED_P;
                end
                RED_P: if (dv_done) begin
                    ra_reg <= dv_rem; state_reg <= ACC;
                end
                ACC: begin
                    // Old total may exceed this modulus, so reduce by remainder unit.
                    prod_reg <= (2*MOD_W)'(acc);
                    neg_reg <= 1'b0; go_reg <= (m_reg != '0);
                    state_reg <= EMIT;
                end
                EMIT: if (m_reg == '0 || dv_done) begin
                    if (last_reg) begin
                        sum_reg <= (m_reg == '0) ? '0 : dv_rem;
                        out_valid_reg <= 1'b1; tot_reg <= '0;
                    end else begin
                        tot_reg <= (m_reg == '0) ? '0 : dv_rem;
                    end
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

// ===== sim/modular_multiply_accumulate_test.sv =====
// Self-checking testbench for the modular multiply-accumulate block.
`timescale 1ns / 100ps

module modular_multiply_accumulate_test;
    import mma_pkg::*;

    localparam int DW = 32;
    localparam int TDW = ((2*DW+31+7)/8)*8;
    localparam int ITEM_CYCLES = 4*62+11;
    localparam int WATCHDOG_LIMIT = 40*ITEM_CYCLES + 2000;

    // Holds the running total and the queue of sums still owed by the block.
    class mac_scoreboard;
        mod_t running_total;
        mod_t sum_queue[$];
        int mismatches;
        int sums_checked;

        function new();
            running_total = '0;
            mismatches = 0;
            sums_checked = 0;
        endfunction

        // Floor residue of a signed operand; m is nonzero.
        function automatic longint unsigned floor_mod(logic signed [DW-1:0] v,
                                                       longint unsigned m);
            longint unsigned mag;
            longint unsigned r;
            mag = v[DW-1] ? longint'(-$signed({1'b1, v})) : longint'(v);
            if (v[DW-1])
                mag = 64'(-longint'(v));
            r = mag % m;
            if (v[DW-1] && r != 0)
                r = m - r;
            return r;
        endfunction

        function void note_word(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                                mod_t m, bit last);
            longint unsigned total;
            longint unsigned ra;
            longint unsigned rb;
            if (m == 0) begin
                total = 0;
            end else begin
                ra = floor_mod(a, m);
                rb = floor_mod(b, m);
                total = (longint'(running_total) + (ra * rb) % m) % m;
            end
            if (last) begin
                sum_queue = {sum_queue, mod_t'(total)};
                running_total = '0;
            end else begin
                running_total = mod_t'(total);
            end
        endfunction

        function void check_word(logic [31:0] data);
            mod_t want;
            if (sum_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h", data);
                return;
            end
            want = sum_queue.pop_front();
            sums_checked++;
            if (data[MOD_W-1:0] !== want || data[31] !== 1'b0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Residue sum mismatch: expected %0d, got %0d (word %h)",
                             want, data[MOD_W-1:0], data);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TDW-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    mac_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;
    int words_sent = 0;

    always #5 aclk = ~aclk;

    modular_multiply_accumulate #(.DATA_WIDTH(DW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Result side: random stalls, plus a long hold-off when asked.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata);
        m_axis_tready <= aresetn && !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                             mod_t m, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(TDW-2*DW-MOD_W){1'b0}}, m, b, a};
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_word(a, b, m, last);
        words_sent++;
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.sum_queue.size() != 0)
            @(posedge aclk);
    endtask

    // Operands biased towards the extremes and small magnitudes.
    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return 32'($signed($urandom_range(20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    function automatic mod_t pick_modulus();
        case ($urandom_range(7))
            0: return mod_t'($urandom_range(2));
            1: return 31'h7fff_ffff - mod_t'($urandom_range(2));
            2: return mod_t'($urandom_range(1000));
            default: return mod_t'($urandom);
        endcase
    endfunction

    task automatic random_runs(int count);
        int n;
        int run_len;
        mod_t m;
        n = 0;
        while (n < count) begin
            run_len = $urandom_range(6, 1);
            m = pick_modulus();
            for (int i = 0; i < run_len; i++) begin
                // Mostly one modulus per run, sometimes a different one mid-run.
                if ($urandom_range(9) == 0)
                    m = pick_modulus();
                send_word(pick_operand(), pick_operand(), m, i == run_len - 1);
                n++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: extremes, unit modulus, zero modulus, total above modulus.
        send_word(32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 1'b1);
        send_word(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 1'b1);
        send_word(32'h8000_0000, 32'h7fff_ffff, 31'h7fff_fffe, 1'b1);
        send_word(-32'sd1, 32'sd1, 31'd7, 1'b1);
        send_word(32'sd0, -32'sd5, 31'd3, 1'b1);
        send_word(32'sd123, 32'sd456, 31'd1, 1'b1);
        send_word(32'sd9, 32'sd9, 31'd100, 1'b0);
        send_word(32'sd9, 32'sd9, 31'd0, 1'b1);
        send_word(32'sd9, 32'sd9, 31'd1000, 1'b0);
        send_word(32'sd5, 32'sd5, 31'd0, 1'b0);
        send_word(32'sd2, 32'sd3, 31'd11, 1'b1);
        send_word(32'h7fff_fff0, 32'h7fff_fff0, 31'h7fff_0000, 1'b0);
        send_word(32'sd1, 32'sd3, 31'd5, 1'b1);
        send_word(-32'sd7, -32'sd9, 31'd10, 1'b0);
        send_word(32'h5555_5555, 32'haaaa_aaaa, 31'h2aaa_aaaa, 1'b1);
        send_word(32'hffff_ffff, 32'hffff_ffff, 31'h5555_5555, 1'b1);
        pause_sender();

        send_idle_pct = 12;
        recv_idle_pct = 74;
        random_runs(600);

        // Receiver holds off while the sender keeps offering words.
        fork
            begin
                hold_off = 1'b1;
                repeat (6*ITEM_CYCLES) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_runs(12);
        join
        pause_sender();

        send_idle_pct = 74;
        recv_idle_pct = 12;
        random_runs(500);
        pause_sender();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_runs(800);

        s_axis_tvalid <= 1'b0;
        while (board.sum_queue.size() != 0)
            @(posedge aclk);
        repeat (3*ITEM_CYCLES) @(posedge aclk);

        $display("Sent %0d operand words, checked %0d residue sums,", words_sent,
                 board.sums_checked);
        $display("covering extreme operands, zero and unit moduli and stalls on both sides.");
        if (board.mismatches == 0 && board.sum_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d sums outstanding", board.mismatches,
                     board.sum_queue.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
